// ===== rtl/core/vsmt_pkg.sv =====
package vsmt_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  localparam int REQ_W    = 2;
  localparam int VOL_W    = 32;
  localparam int SRV_W    = 64;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;

  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK              = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT_OR_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL            = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NO_PAIR         = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [VOL_W-1:0] volume_key;
    logic [SRV_W-1:0] server_tag;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [SRV_W-1:0]    server_out;
    logic [SLOT_W-1:0]   slot_index;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic scan;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/core/vsmt_ctrl.sv =====
module vsmt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  vsmt_pkg::dp_sts_t sts,
  output vsmt_pkg::ctl_cmd_t cmd
);
  import vsmt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        // Hold here until the result register can take the new item.
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready   = (state_r == S_IDLE);
  assign cmd.start  = (state_r == S_IDLE) && in_valid;
  assign cmd.scan   = (state_r == S_SCAN);
  assign cmd.commit = (state_r == S_COMMIT) && sts.out_free;

endmodule

// ===== rtl/core/vsmt_datapath.sv =====
module vsmt_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  vsmt_pkg::in_item_t  in_data,
  input  vsmt_pkg::ctl_cmd_t  cmd,
  output vsmt_pkg::dp_sts_t   sts,
  output logic                out_valid,
  input  logic                out_ready,
  output vsmt_pkg::out_item_t out_data
);
  import vsmt_pkg::*;

  localparam int ENTRY_W = VOL_W + SRV_W;

  // Table contents live in a memory; presence is tracked by flip-flop valid bits.
  logic [ENTRY_W-1:0]       tbl_mem_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;

  in_item_t           req_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [ENTRY_W-1:0] rd_data_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               rd_live_r;
  logic               hit_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic [SRV_W-1:0]   hit_srv_r;
  logic               free_r;
  logic [IDX_W-1:0]   free_idx_r;
  logic               out_valid_r;
  out_item_t          out_data_r;

  logic               cnt_live;
  logic [VOL_W-1:0]   rd_vol;
  logic [SRV_W-1:0]   rd_srv;
  logic               entry_valid;
  out_item_t          result;
  logic               do_insert;
  logic               do_remove;

  assign cnt_live    = (cnt_r < CNT_W'(TABLE_ENTRIES));
  assign rd_vol      = rd_data_r[ENTRY_W-1 -: VOL_W];
  assign rd_srv      = rd_data_r[SRV_W-1:0];
  assign entry_valid = valid_r[rd_idx_r];

  assign sts.scan_done = cmd.scan && !cnt_live && !rd_live_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  // Scan: one entry is read per cycle and compared on the following cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      rd_live_r <= 1'b0;
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
    end else if (cmd.start) begin
      cnt_r     <= '0;
      rd_live_r <= 1'b0;
      hit_r     <= 1'b0;
      free_r    <= 1'b0;
    end else begin
      rd_live_r <= cmd.scan && cnt_live;
      if (cmd.scan && cnt_live) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (rd_live_r) begin
        if (entry_valid && (rd_vol == req_r.volume_key) && !hit_r) begin
          hit_r <= 1'b1;
        end
        if (!entry_valid && !free_r) begin
          free_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req_r <= in_data;
    end
    rd_idx_r <= cnt_r[IDX_W-1:0];
    if (rd_live_r && entry_valid && (rd_vol == req_r.volume_key) && !hit_r) begin
      hit_idx_r <= rd_idx_r;
      hit_srv_r <= rd_srv;
    end
    if (rd_live_r && !entry_valid && !free_r) begin
      free_idx_r <= rd_idx_r;
    end
  end

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (do_insert) begin
      tbl_mem_r[free_idx_r] <= {req_r.volume_key, req_r.server_tag};
    end
    rd_data_r <= tbl_mem_r[cnt_r[IDX_W-1:0]];
  end

  always_comb begin
    result            = '0;
    result.status     = ST_PRESENT_OR_MISS;
    do_insert         = 1'b0;
    do_remove         = 1'b0;
    case (req_r.req_type)
      REQ_INSERT: begin
        if (hit_r) begin
          result.status     = ST_PRESENT_OR_MISS;
          result.found      = 1'b1;
          result.server_out = hit_srv_r;
          result.slot_index = SLOT_W'(hit_idx_r);
        end else if (free_r) begin
          result.status     = ST_OK;
          result.server_out = req_r.server_tag;
          result.slot_index = SLOT_W'(free_idx_r);
          do_insert         = cmd.commit;
        end else begin
          result.status = ST_FULL;
        end
      end
      REQ_REMOVE: begin
        if (!hit_r) begin
          result.status = ST_NO_PAIR;
        end else begin
          result.found      = 1'b1;
          result.server_out = hit_srv_r;
          result.slot_index = SLOT_W'(hit_idx_r);
          if (hit_srv_r == req_r.server_tag) begin
            result.status = ST_OK;
            do_remove     = cmd.commit;
          end else begin
            result.status = ST_NO_PAIR;
          end
        end
      end
      default: begin
        // Lookup; the unused request code behaves the same way.
        if (hit_r) begin
          result.status     = ST_OK;
          result.found      = 1'b1;
          result.server_out = hit_srv_r;
          result.slot_index = SLOT_W'(hit_idx_r);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (do_insert) begin
        valid_r[free_idx_r] <= 1'b1;
      end else if (do_remove) begin
        valid_r[hit_idx_r] <= 1'b0;
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/volume_server_map_table.sv =====
// Volume-to-server map table with lookup, insert and remove requests.
//
// Requests arrive on the in_ channel (valid/ready) as one in_item_t holding
// the request type, the volume id and the server id. Each request yields
// exactly one item on the out_ channel (valid/ready) with a status, a found
// flag, the stored server id and the entry index.
//
// Every request scans the whole table, one entry per cycle through the
// table memory's single read port, with the compare in the cycle after the
// read. Requests are handled one at a time: a new request can be accepted
// in the cycle after a result is loaded.
//
// A finished result waits in an output register; the next request is
// accepted while it waits. If the receiver still stalls when the following
// result is ready, the block holds that result and takes no new request.
// Reset clears every valid bit, leaving the table empty, and drops any
// pending result.
module volume_server_map_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  vsmt_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output vsmt_pkg::out_item_t out_data
);
  import vsmt_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  vsmt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  vsmt_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
